// ----- hw/rtl/slv3_pkg.sv -----
package slv3_pkg;

    localparam int DATA_WIDTH_C = 32;
    localparam int FRAC_BITS_C  = 16;

    // det of 3x3 with W-bit entries fits in 3W+2 signed bits with margin
    localparam int DET_W = 3 * DATA_WIDTH_C + 2;

    typedef logic [DATA_WIDTH_C-1:0] word_t;
    typedef word_t [2:0][2:0] mat_t;

    typedef struct packed {
        word_t m00;
        word_t m01;
        word_t m02;
        word_t m10;
        word_t m11;
        word_t m12;
        word_t m20;
        word_t m21;
        word_t m22;
        word_t rhs0;
        word_t rhs1;
        word_t rhs2;
    } operand_t;

    typedef struct packed {
        word_t sol0;
        word_t sol1;
        word_t sol2;
        logic  singular;
    } result_t;

    typedef struct packed {
        word_t quot;
        logic  ovf;
        logic  neg;
        logic  zero;
    } div_out_t;

endpackage

// ----- hw/rtl/slv3_det_lane.sv -----
module slv3_det_lane
    import slv3_pkg::*;
(
    input  logic                    clk,
    input  mat_t                    mat,
    output logic signed [DET_W-1:0] det
);

    localparam int W = DATA_WIDTH_C;

    logic signed [2*W-1:0]   p_reg [6];
    word_t                   row0_s1_reg [3];
    logic signed [2*W:0]     c_reg [3];
    word_t                   row0_s2_reg [3];
    logic signed [2*W:0]     pl_reg [3];
    logic signed [2*W:0]     ph_reg [3];
    logic signed [DET_W-1:0] term_reg [3];
    logic signed [DET_W-1:0] term_next [3];
    logic signed [DET_W-1:0] det_reg;

    // stage 1: 2x2 minor products
    always_ff @(posedge clk)
    begin
        p_reg[0] <= (2*W)'($signed(mat[1][1])) * (2*W)'($signed(mat[2][2]));
        p_reg[1] <= (2*W)'($signed(mat[1][2])) * (2*W)'($signed(mat[2][1]));
        p_reg[2] <= (2*W)'($signed(mat[1][0])) * (2*W)'($signed(mat[2][2]));
        p_reg[3] <= (2*W)'($signed(mat[1][2])) * (2*W)'($signed(mat[2][0]));
        p_reg[4] <= (2*W)'($signed(mat[1][0])) * (2*W)'($signed(mat[2][1]));
        p_reg[5] <= (2*W)'($signed(mat[1][1])) * (2*W)'($signed(mat[2][0]));
        for (int t = 0; t < 3; t++)
        begin
            row0_s1_reg[t] <= mat[0][t];
        end
    end

    // stage 2: cofactors
    always_ff @(posedge clk)
    begin
        for (int t = 0; t < 3; t++)
        begin
            c_reg[t]       <= (2*W+1)'(p_reg[2*t]) - (2*W+1)'(p_reg[2*t+1]);
            row0_s2_reg[t] <= row0_s1_reg[t];
        end
    end

    // stage 3: row-0 entry times cofactor, cofactor split into low/high halves
    always_ff @(posedge clk)
    begin
        for (int t = 0; t < 3; t++)
        begin
            pl_reg[t] <= (2*W+1)'($signed(row0_s2_reg[t]))
                         * $signed({{(W+1){1'b0}}, c_reg[t][W-1:0]});
            ph_reg[t] <= (2*W+1)'($signed(row0_s2_reg[t]))
                         * (2*W+1)'($signed(c_reg[t][2*W:W]));
        end
    end

    // stage 4: recombine partial products
    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            logic signed [DET_W-1:0] hx;
            logic signed [DET_W-1:0] lx;
            hx = DET_W'(ph_reg[t]);
            lx = DET_W'(pl_reg[t]);
            term_next[t] = (hx <<< W) + lx;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
    end

    // stage 5: expansion along row 0
    always_ff @(posedge clk)
    begin
        det_reg <= term_reg[0] - term_reg[1] + term_reg[2];
    end

    assign det = det_reg;

endmodule

// ----- hw/rtl/slv3_div_lane.sv -----
module slv3_div_lane
    import slv3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_C
)
(
    input  logic                    clk,
    input  logic signed [DET_W-1:0] num,
    input  logic signed [DET_W-1:0] den,
    output div_out_t                res
);

    localparam int W  = DATA_WIDTH_C;
    localparam int XW = DET_W + FRAC_BITS + W;

    logic [XW-1:0] na_reg;
    logic [XW-1:0] da_reg;
    logic          nega_reg;
    logic          zeroa_reg;
    logic [DET_W-1:0] magn;
    logic [DET_W-1:0] magd;

    logic [XW-1:0] r_reg [W];
    logic [XW-1:0] d_reg [W];
    word_t         q_reg [W+1];
    logic          ovf_reg [W+1];
    logic          neg_reg [W+1];
    logic          zero_reg [W+1];

    assign magn = num[DET_W-1] ? DET_W'(-num) : DET_W'(num);
    assign magd = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);

    // stage A: magnitudes and sign
    always_ff @(posedge clk)
    begin
        na_reg    <= XW'(magn) << FRAC_BITS;
        da_reg    <= XW'(magd);
        nega_reg  <= num[DET_W-1] ^ den[DET_W-1];
        zeroa_reg <= (den == '0);
    end

    // stage B: quotient at or above 2^W saturates in any case
    always_ff @(posedge clk)
    begin
        r_reg[0]    <= na_reg;
        d_reg[0]    <= da_reg;
        q_reg[0]    <= '0;
        ovf_reg[0]  <= (na_reg >= (da_reg << W));
        neg_reg[0]  <= nega_reg;
        zero_reg[0] <= zeroa_reg;
    end

    // one restoring step per stage, MSB of the quotient first
    for (genvar i = 0; i < W; i++)
    begin : g_step
        localparam int B = W - 1 - i;
        logic [XW-1:0] sh;
        logic          take;
        assign sh   = d_reg[i] << B;
        assign take = (r_reg[i] >= sh);

        always_ff @(posedge clk)
        begin
            q_reg[i+1]    <= take ? (q_reg[i] | (W'(1) << B)) : q_reg[i];
            ovf_reg[i+1]  <= ovf_reg[i];
            neg_reg[i+1]  <= neg_reg[i];
            zero_reg[i+1] <= zero_reg[i];
        end

        if (i < W - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                r_reg[i+1] <= take ? (r_reg[i] - sh) : r_reg[i];
                d_reg[i+1] <= d_reg[i];
            end
        end
    end

    assign res.quot = q_reg[W];
    assign res.ovf  = ovf_reg[W];
    assign res.neg  = neg_reg[W];
    assign res.zero = zero_reg[W];

endmodule

// ----- hw/rtl/slv3_merge.sv -----
module slv3_merge
    import slv3_pkg::*;
(
    input  logic     clk,
    input  div_out_t lane [3],
    output result_t  result
);

    localparam int W = DATA_WIDTH_C;

    localparam word_t MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam word_t MIN_NEG = {1'b1, {(W-1){1'b0}}};

    word_t   sol [3];
    result_t res_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (lane[0].zero)
            begin
                sol[j] = '0;
            end
            else if (lane[j].ovf || lane[j].quot[W-1])
            begin
                // negative side: magnitude of exactly half also lands on min
                sol[j] = lane[j].neg ? MIN_NEG : MAX_POS;
            end
            else
            begin
                sol[j] = lane[j].neg ? word_t'(-lane[j].quot) : lane[j].quot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg.sol0     <= sol[0];
        res_reg.sol1     <= sol[1];
        res_reg.sol2     <= sol[2];
        res_reg.singular <= lane[0].zero;
    end

    assign result = res_reg;

endmodule

// ----- hw/rtl/solve_3x3_linear_system_cramer_core.sv -----
// 3x3 linear solver, Cramer's rule, signed fixed point.
//
// Input channel: drive operand and raise start; the word is taken at any
// edge with start high and busy low. busy is always low: the pipeline takes
// one system every cycle.
// Output channel: done pulses for one cycle with result valid in that cycle.
// The receiver cannot stall; results leave in input order.
//
// Pipeline: the four determinant lanes register products, cofactors, split
// products, recombine and sum; the three divider lanes register magnitudes
// and sign, the saturation check and one quotient bit per stage; then the
// saturation/merge stage. Throughput: one word per cycle.
//
// Quotients truncate toward zero and saturate to the signed range. A zero
// determinant gives zero solutions with singular set.
// Reset clears the valid pipeline only; no result appears until the first
// accepted word has passed through.
module solve_3x3_linear_system_cramer_core
    import slv3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_C
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  operand_t operand,
    output logic     done,
    output result_t  result
);

    localparam int W   = DATA_WIDTH_C;
    localparam int LAT = W + 8;

    mat_t                    mat [4];
    logic signed [DET_W-1:0] det [4];
    div_out_t                lane [3];
    logic [LAT-1:0]          vld_reg;
    logic [LAT-1:0]          vld_next;

    assign busy = 1'b0;

    always_comb
    begin
        mat[0][0][0] = operand.m00;
        mat[0][0][1] = operand.m01;
        mat[0][0][2] = operand.m02;
        mat[0][1][0] = operand.m10;
        mat[0][1][1] = operand.m11;
        mat[0][1][2] = operand.m12;
        mat[0][2][0] = operand.m20;
        mat[0][2][1] = operand.m21;
        mat[0][2][2] = operand.m22;
        // column j replaced by the right-hand side
        for (int j = 0; j < 3; j++)
        begin
            mat[j+1]       = mat[0];
            mat[j+1][0][j] = operand.rhs0;
            mat[j+1][1][j] = operand.rhs1;
            mat[j+1][2][j] = operand.rhs2;
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_det
        slv3_det_lane u_det (
            .clk (clk),
            .mat (mat[k]),
            .det (det[k])
        );
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_div
        slv3_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .num (det[j+1]),
            .den (det[0]),
            .res (lane[j])
        );
    end

    slv3_merge u_merge (
        .clk    (clk),
        .lane   (lane),
        .result (result)
    );

    assign vld_next = {vld_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign done = vld_reg[LAT-1];

endmodule
